@@ rtl/core/lsmd_pkg.sv @@
// Shared types and fixed constants for the lidar sector minimum distance block.
package lsmd_pkg;

   localparam int ANGLE_W    = 16;
   localparam int DIST_W     = 18;
   localparam int MM_W       = 16;
   localparam int REPORTED   = 4;
   localparam int FULL_TURN  = 360;
   localparam int DEG_PER_Q  = 90;
   localparam int Q_FRAC     = 14;
   localparam int DIST_FRAC  = 2;
   localparam int SUM_W      = 23;   // angle * 90 plus half span plus half lsb
   localparam int RDEG_W     = 9;    // rounded degrees, at most 450
   localparam int RECIP_FRAC = 16;

   typedef logic [MM_W-1:0] mm_type;

   typedef struct packed {
      logic off_zero;
      logic off_one;
   } offset_flags_type;

endpackage

@@ rtl/core/lsmd_angle.sv @@
// Two-stage angle pipeline: rounded degrees, then sector offset flags.
module lsmd_angle #(
   parameter int SECTORS = 4
) (
   input  logic                           clock,
   input  logic                           load_deg,
   input  logic                           load_off,
   input  logic [lsmd_pkg::ANGLE_W-1:0]   angle_q14,
   output lsmd_pkg::offset_flags_type     flags
);
   import lsmd_pkg::*;

   localparam int SPAN      = FULL_TURN / SECTORS;
   localparam int HALF      = SPAN / 2;
   localparam int RECIP     = (1 << RECIP_FRAC) / SPAN;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = RDEG_W + RECIP_W;
   localparam int QUOT_W    = PROD_W - RECIP_FRAC;

   logic [SUM_W-1:0]   sum_w;
   logic [RDEG_W-1:0]  rdeg_ff, rdeg_in;
   logic [PROD_W-1:0]  prod_w;
   logic [QUOT_W-1:0]  quot_w;
   logic [RDEG_W-1:0]  rem0_w, rem_w, off_w;
   offset_flags_type   flags_ff, flags_in;

   // round half up of angle in degrees plus half a sector
   assign sum_w   = SUM_W'(angle_q14) * SUM_W'(DEG_PER_Q)
                  + SUM_W'(HALF * (1 << Q_FRAC))
                  + SUM_W'(1 << (Q_FRAC - 1));
   assign rdeg_in = sum_w[SUM_W-1:Q_FRAC];

   // modulo by the span: reciprocal estimate, low by at most one
   assign prod_w  = PROD_W'(rdeg_ff) * PROD_W'(RECIP);
   assign quot_w  = prod_w[PROD_W-1:RECIP_FRAC];
   assign rem0_w  = rdeg_ff - RDEG_W'(RDEG_W'(quot_w) * RDEG_W'(SPAN));

   always_comb begin
      rem_w = rem0_w;
      if (rem0_w >= RDEG_W'(SPAN)) begin
         rem_w = rem0_w - RDEG_W'(SPAN);
      end
      if (rem_w >= RDEG_W'(HALF)) begin
         off_w = rem_w - RDEG_W'(HALF);
      end else begin
         off_w = RDEG_W'(HALF) - rem_w;
      end
      flags_in.off_zero = (off_w == '0);
      flags_in.off_one  = (off_w == RDEG_W'(1));
   end

   always_ff @(posedge clock) begin
      if (load_deg) begin
         rdeg_ff <= rdeg_in;
      end
      if (load_off) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

@@ rtl/core/lsmd_sector_acc.sv @@
// Per-sector minimum tracking, sector counter and result register.
module lsmd_sector_acc #(
   parameter int SECTORS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  lsmd_pkg::offset_flags_type  flags,
   input  lsmd_pkg::mm_type            dist_mm,
   input  logic                        scan_last,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output lsmd_pkg::mm_type            result [lsmd_pkg::REPORTED]
);
   import lsmd_pkg::*;

   localparam int IDX_W = $clog2(SECTORS);

   mm_type             min_ff  [SECTORS];
   mm_type             min_in  [SECTORS];
   mm_type             min_upd [SECTORS];
   mm_type             out_ff  [REPORTED];
   mm_type             out_in  [REPORTED];
   logic [IDX_W-1:0]   idx_ff, idx_in, idx_next;
   logic [IDX_W:0]     idx_inc;
   logic               prev_one_ff, prev_one_in;
   logic               valid_ff, valid_in;

   always_comb begin
      idx_inc = {1'b0, idx_ff};
      if (flags.off_zero && prev_one_ff) begin
         idx_inc = {1'b0, idx_ff} + (IDX_W+1)'(1);
      end
      if (idx_inc >= (IDX_W+1)'(SECTORS)) begin
         idx_next = '0;
      end else begin
         idx_next = idx_inc[IDX_W-1:0];
      end
   end

   // empty slot takes anything; zero never replaces a non-zero minimum
   always_comb begin
      for (int k = 0; k < SECTORS; k++) begin
         min_upd[k] = min_ff[k];
         if (idx_next == IDX_W'(k)) begin
            if (min_ff[k] == '0 || (dist_mm != '0 && min_ff[k] > dist_mm)) begin
               min_upd[k] = dist_mm;
            end
         end
      end
   end

   always_comb begin
      idx_in      = idx_ff;
      prev_one_in = prev_one_ff;
      for (int k = 0; k < SECTORS; k++) begin
         min_in[k] = min_ff[k];
      end
      for (int k = 0; k < REPORTED; k++) begin
         out_in[k] = out_ff[k];
      end
      valid_in = rsp_ready ? 1'b0 : valid_ff;
      if (step) begin
         if (scan_last) begin
            idx_in      = '0;
            prev_one_in = 1'b0;
            for (int k = 0; k < SECTORS; k++) begin
               min_in[k] = '0;
            end
            for (int k = 0; k < REPORTED; k++) begin
               out_in[k] = (k < SECTORS) ? min_upd[k % SECTORS] : '0;
            end
            valid_in = 1'b1;
         end else begin
            idx_in      = idx_next;
            prev_one_in = flags.off_one;
            for (int k = 0; k < SECTORS; k++) begin
               min_in[k] = min_upd[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         prev_one_ff <= 1'b0;
         valid_ff    <= 1'b0;
         for (int k = 0; k < SECTORS; k++) begin
            min_ff[k] <= '0;
         end
      end else begin
         idx_ff      <= idx_in;
         prev_one_ff <= prev_one_in;
         valid_ff    <= valid_in;
         for (int k = 0; k < SECTORS; k++) begin
            min_ff[k] <= min_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < REPORTED; k++) begin
         out_ff[k] <= out_in[k];
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = out_ff;

endmodule

@@ rtl/core/lidar_sector_min_distance.sv @@
// Top level: lidar sector minimum distance, three-stage sample pipeline.
//
//   channel  direction  beat contents
//   req_     in         angle_q14, dist_q2, scan_last
//   rsp_     out        sector0_min .. sector3_min (one beat per scan)
//
// One sample beat is taken every cycle while req_ready is high. A result beat
// appears once the scan's last sample has passed the rounded-degree register
// and the offset-flag register into the sector minimum/result register.
// Reset clears the sector minima, the sector counter and all valid flags.
// Only a last-sample beat waits, in the offset stage, while an unread result
// still sits in the result register; samples behind it back up meanwhile.
module lidar_sector_min_distance #(
   parameter int SECTORS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lsmd_pkg::ANGLE_W-1:0]   req_angle_q14,
   input  logic [lsmd_pkg::DIST_W-1:0]    req_dist_q2,
   input  logic                           req_scan_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lsmd_pkg::mm_type               rsp_sector0_min,
   output lsmd_pkg::mm_type               rsp_sector1_min,
   output lsmd_pkg::mm_type               rsp_sector2_min,
   output lsmd_pkg::mm_type               rsp_sector3_min
);
   import lsmd_pkg::*;

   logic               v1_ff, v1_in, v2_ff, v2_in;
   mm_type             mm1_ff, mm2_ff;
   logic               last1_ff, last2_ff;
   logic               step, ready2, ready1;
   offset_flags_type   flags;
   mm_type             result [REPORTED];

   // hold a last-sample beat while the previous result is still unread
   assign step      = v2_ff && !(last2_ff && rsp_valid && !rsp_ready);
   assign ready2    = !v2_ff || step;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;

   always_comb begin
      v1_in = v1_ff;
      v2_in = v2_ff;
      if (ready2) begin
         v2_in = v1_ff;
      end
      if (ready1) begin
         v1_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // carry distance (truncated to whole millimetres) and the scan marker along
   always_ff @(posedge clock) begin
      if (ready1) begin
         mm1_ff   <= req_dist_q2[DIST_W-1:DIST_FRAC];
         last1_ff <= req_scan_last;
      end
      if (ready2) begin
         mm2_ff   <= mm1_ff;
         last2_ff <= last1_ff;
      end
   end

   lsmd_angle #(
      .SECTORS   (SECTORS)
   ) u_angle (
      .clock     (clock),
      .load_deg  (ready1),
      .load_off  (ready2),
      .angle_q14 (req_angle_q14),
      .flags     (flags)
   );

   lsmd_sector_acc #(
      .SECTORS   (SECTORS)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .flags     (flags),
      .dist_mm   (mm2_ff),
      .scan_last (last2_ff),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .result    (result)
   );

   assign rsp_sector0_min = result[0];
   assign rsp_sector1_min = result[1];
   assign rsp_sector2_min = result[2];
   assign rsp_sector3_min = result[3];

endmodule
